// File: hdl/sfc_pkg.sv
// Shared widths, codes and register map of the sphere frustum culling block.
package sfc_pkg;

	localparam int VAL_W   = 32;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int TOT_W   = PROD_W + 2;
	localparam int DR_W    = VAL_W + 1;
	localparam int FRAC_W  = 16;
	localparam int LAYER_W = 64;
	localparam int ID_W    = 24;
	localparam int PIDX_W  = 3;
	localparam int IDX_W   = 5;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 64;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_TEST = 1'b1
	} action_t;

	typedef enum logic {
		REG_QUERY_LAYERS = 1'b0
	} reg_index_t;

endpackage

// File: hdl/sphere_frustum_cull.sv
// Top level: bounding sphere test against a frustum held in a plane store.
//
// Input channel (in_valid / in_stall): a load transaction (action 0) writes
// one plane a,b,c,d into the store at plane_index; an index beyond the store
// is dropped. A test transaction (action 1) brings a sphere centre and radius,
// layer bits, an id and a batch-last mark, and gives exactly one result.
// Output channel (out_valid / out_stall): result_id, visible, result_last.
// One transaction is accepted every cycle while in_stall is low. A test
// result passes five register stages in order: input, three products per
// plane, partial sums, per-plane sign, output register.
// Each stage has its own valid bit and fills while later stages hold, so
// input is still taken while a result waits on out_stall until the first
// stage is also full. A load takes effect for every test accepted after it.
// Reset empties the pipeline, clears all planes to zero and sets the layer
// query register to all ones. The APB port holds query_layers at address 0;
// write it only while no test is in flight.
module sphere_frustum_cull #(
	parameter int PLANE_COUNT = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [sfc_pkg::PIDX_W-1:0]    plane_index,
	input  logic signed [sfc_pkg::VAL_W-1:0] value_x,
	input  logic signed [sfc_pkg::VAL_W-1:0] value_y,
	input  logic signed [sfc_pkg::VAL_W-1:0] value_z,
	input  logic signed [sfc_pkg::VAL_W-1:0] value_w,
	input  logic [sfc_pkg::LAYER_W-1:0]   object_layers,
	input  logic [sfc_pkg::ID_W-1:0]      object_id,
	input  logic                          batch_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sfc_pkg::ID_W-1:0]      result_id,
	output logic                          visible,
	output logic                          result_last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfc_pkg::ADDR_W-1:0]    paddr,
	input  logic [sfc_pkg::DATA_W-1:0]    pwdata,
	output logic [sfc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import sfc_pkg::*;

	logic [LAYER_W-1:0] query_layers_q;

	logic signed [VAL_W-1:0] nx_q [PLANE_COUNT];
	logic signed [VAL_W-1:0] ny_q [PLANE_COUNT];
	logic signed [VAL_W-1:0] nz_q [PLANE_COUNT];
	logic signed [VAL_W-1:0] nd_q [PLANE_COUNT];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic in_take, take_test, take_load, cfg_wr;

	logic signed [VAL_W-1:0] x_s1, y_s1, z_s1, r_s1;
	logic [ID_W-1:0]         id_s1, id_s2, id_s3, id_s4, id_s5;
	logic                    last_s1, last_s2, last_s3, last_s4, last_s5;
	logic                    hit_s1, hit_s2, hit_s3, hit_s4;
	logic                    vis_s5;

	logic signed [PROD_W-1:0] px_s2 [PLANE_COUNT];
	logic signed [PROD_W-1:0] py_s2 [PLANE_COUNT];
	logic signed [PROD_W-1:0] pz_s2 [PLANE_COUNT];
	logic signed [DR_W-1:0]   dr_s2 [PLANE_COUNT];
	logic signed [SUM_W-1:0]  sxy_s3 [PLANE_COUNT];
	logic signed [SUM_W-1:0]  szb_s3 [PLANE_COUNT];
	logic [PLANE_COUNT-1:0]   neg_s4;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready &&
	                  (reg_index_t'(paddr[ADDR_W-1]) == REG_QUERY_LAYERS);
	assign prdata   = (reg_index_t'(paddr[ADDR_W-1]) == REG_QUERY_LAYERS) ?
	                  query_layers_q : '0;

	assign rdy_s5    = !v_s5 || !out_stall;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign in_stall  = !rdy_s1;
	assign in_take   = in_valid && rdy_s1;
	assign take_test = in_take && (action_t'(action) == ACT_TEST);
	assign take_load = in_take && (action_t'(action) == ACT_LOAD);

	assign out_valid   = v_s5;
	assign result_id   = id_s5;
	assign visible     = vis_s5;
	assign result_last = last_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_layers_q <= '1;
		end else if (cfg_wr) begin
			query_layers_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PLANE_COUNT; k++) begin
				nx_q[k] <= '0;
				ny_q[k] <= '0;
				nz_q[k] <= '0;
				nd_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < PLANE_COUNT; k++) begin
				if (take_load && (IDX_W'(plane_index) == IDX_W'(k))) begin
					nx_q[k] <= value_x;
					ny_q[k] <= value_y;
					nz_q[k] <= value_z;
					nd_q[k] <= value_w;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= take_test;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			x_s1    <= value_x;
			y_s1    <= value_y;
			z_s1    <= value_z;
			r_s1    <= value_w;
			id_s1   <= object_id;
			last_s1 <= batch_last;
			hit_s1  <= |(object_layers & query_layers_q);
		end
		if (rdy_s2) begin
			for (int k = 0; k < PLANE_COUNT; k++) begin
				px_s2[k] <= x_s1 * nx_q[k];
				py_s2[k] <= y_s1 * ny_q[k];
				pz_s2[k] <= z_s1 * nz_q[k];
				dr_s2[k] <= DR_W'(nd_q[k]) + DR_W'(r_s1);
			end
			id_s2   <= id_s1;
			last_s2 <= last_s1;
			hit_s2  <= hit_s1;
		end
		if (rdy_s3) begin
			for (int k = 0; k < PLANE_COUNT; k++) begin
				sxy_s3[k] <= SUM_W'(px_s2[k]) + SUM_W'(py_s2[k]);
				szb_s3[k] <= SUM_W'(pz_s2[k]) +
				             SUM_W'($signed({dr_s2[k], {FRAC_W{1'b0}}}));
			end
			id_s3   <= id_s2;
			last_s3 <= last_s2;
			hit_s3  <= hit_s2;
		end
		if (rdy_s4) begin
			for (int k = 0; k < PLANE_COUNT; k++) begin
				neg_s4[k] <= ((TOT_W'(sxy_s3[k]) + TOT_W'(szb_s3[k])) >>> (TOT_W - 1)) != '0;
			end
			id_s4   <= id_s3;
			last_s4 <= last_s3;
			hit_s4  <= hit_s3;
		end
		if (rdy_s5) begin
			vis_s5  <= hit_s4 && !(|neg_s4);
			id_s5   <= id_s4;
			last_s5 <= last_s4;
		end
	end

`ifndef SYNTHESIS
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_load |=> !v_s1)
		else $error("load transaction entered the pipeline");
	a_test_enters: assert property (@(posedge clk) disable iff (!arst_n)
		take_test |=> v_s1)
		else $error("accepted test transaction lost at first stage");
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_stall))
		else $error("input stalled while pipeline has room");
`endif

endmodule

// File: sim/tb_sphere_frustum_cull.sv
// Testbench for sphere_frustum_cull: random and directed spheres checked against a plane predictor.
`timescale 1ns / 1ps

module tb_sphere_frustum_cull;
	import sfc_pkg::*;

	localparam int PLANE_COUNT = 8;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [VAL_W-1:0] VMAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VMIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] UNIT = 32'sd65536;
	localparam logic [LAYER_W-1:0] ALL_LAYERS = '1;

	typedef struct {
		action_t                   act;
		logic [PIDX_W-1:0]         pidx;
		logic signed [VAL_W-1:0]   vx;
		logic signed [VAL_W-1:0]   vy;
		logic signed [VAL_W-1:0]   vz;
		logic signed [VAL_W-1:0]   vw;
		logic [LAYER_W-1:0]        layers;
		logic [ID_W-1:0]           id;
		logic                      last;
	} cull_item_t;

	typedef struct {
		logic [ID_W-1:0] id;
		logic            vis;
		logic            last;
	} cull_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [PIDX_W-1:0] plane_index = '0;
	logic signed [VAL_W-1:0] value_x = '0;
	logic signed [VAL_W-1:0] value_y = '0;
	logic signed [VAL_W-1:0] value_z = '0;
	logic signed [VAL_W-1:0] value_w = '0;
	logic [LAYER_W-1:0] object_layers = '0;
	logic [ID_W-1:0] object_id = '0;
	logic batch_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ID_W-1:0] result_id;
	logic visible;
	logic result_last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	cull_item_t pending_items[$];
	cull_verdict_t expected_verdicts[$];
	cull_item_t driven_item;

	logic signed [VAL_W-1:0] plane_a[PLANE_COUNT];
	logic signed [VAL_W-1:0] plane_b[PLANE_COUNT];
	logic signed [VAL_W-1:0] plane_c[PLANE_COUNT];
	logic signed [VAL_W-1:0] plane_d[PLANE_COUNT];
	logic [LAYER_W-1:0] layer_query = '1;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_queued = 0;
	int mismatches = 0;
	int cycle_count = 0;

	sphere_frustum_cull #(
		.PLANE_COUNT(PLANE_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.plane_index(plane_index),
		.value_x(value_x),
		.value_y(value_y),
		.value_z(value_z),
		.value_w(value_w),
		.object_layers(object_layers),
		.object_id(object_id),
		.batch_last(batch_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_id(result_id),
		.visible(visible),
		.result_last(result_last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic void cull_predict(input cull_item_t it);
		logic signed [127:0] acc;
		logic in_frustum;
		cull_verdict_t v;
		if (it.act == ACT_LOAD) begin
			if (int'(it.pidx) < PLANE_COUNT) begin
				plane_a[it.pidx] = it.vx;
				plane_b[it.pidx] = it.vy;
				plane_c[it.pidx] = it.vz;
				plane_d[it.pidx] = it.vw;
			end
		end else begin
			in_frustum = 1'b1;
			for (int k = 0; k < PLANE_COUNT; k++) begin
				acc = it.vx * plane_a[k];
				acc = acc + it.vy * plane_b[k];
				acc = acc + it.vz * plane_c[k];
				acc = acc + (plane_d[k] <<< FRAC_W);
				acc = acc + (it.vw <<< FRAC_W);
				if (acc[127])
					in_frustum = 1'b0;
			end
			v.id = it.id;
			v.vis = in_frustum && ((it.layers & layer_query) != '0);
			v.last = it.last;
			expected_verdicts.insert(expected_verdicts.size(), v);
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				cull_predict(driven_item);
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					driven_item = pending_items.pop_front();
					in_valid <= 1'b1;
					action <= driven_item.act;
					plane_index <= driven_item.pidx;
					value_x <= driven_item.vx;
					value_y <= driven_item.vy;
					value_z <= driven_item.vz;
					value_w <= driven_item.vw;
					object_layers <= driven_item.layers;
					object_id <= driven_item.id;
					batch_last <= driven_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cull_verdict_t v;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					$error("unexpected result transaction: result_id %0h", result_id);
					mismatches++;
				end else begin
					v = expected_verdicts.pop_front();
					if (result_id !== v.id) begin
						$error("result_id: expected %0h, actual %0h", v.id, result_id);
						mismatches++;
					end
					if (visible !== v.vis) begin
						$error("visible: expected %0b, actual %0b", v.vis, visible);
						mismatches++;
					end
					if (result_last !== v.last) begin
						$error("result_last: expected %0b, actual %0b", v.last, result_last);
						mismatches++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		for (int k = 0; k < PLANE_COUNT; k++) begin
			plane_a[k] = '0;
			plane_b[k] = '0;
			plane_c[k] = '0;
			plane_d[k] = '0;
		end
	end

	task automatic push_load(input int idx, input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b, input logic signed [VAL_W-1:0] c,
			input logic signed [VAL_W-1:0] d);
		cull_item_t it;
		it.act = ACT_LOAD;
		it.pidx = PIDX_W'(idx);
		it.vx = a;
		it.vy = b;
		it.vz = c;
		it.vw = d;
		it.layers = {$urandom(), $urandom()};
		it.id = ID_W'($urandom());
		it.last = 1'($urandom());
		pending_items.insert(pending_items.size(), it);
		items_queued++;
	endtask

	task automatic push_test(input logic signed [VAL_W-1:0] x,
			input logic signed [VAL_W-1:0] y, input logic signed [VAL_W-1:0] z,
			input logic signed [VAL_W-1:0] r, input logic [LAYER_W-1:0] layers,
			input logic [ID_W-1:0] id, input logic last);
		cull_item_t it;
		it.act = ACT_TEST;
		it.pidx = PIDX_W'($urandom());
		it.vx = x;
		it.vy = y;
		it.vz = z;
		it.vw = r;
		it.layers = layers;
		it.id = id;
		it.last = last;
		pending_items.insert(pending_items.size(), it);
		items_queued++;
	endtask

	function automatic logic signed [VAL_W-1:0] around_zero(input int mag);
		return VAL_W'($urandom_range(2 * mag)) - VAL_W'(mag);
	endfunction

	function automatic logic [LAYER_W-1:0] pick_layers();
		case ($urandom_range(5))
			0: return '0;
			1: return 64'd1 << $urandom_range(LAYER_W - 1);
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_query(input logic [LAYER_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(8 * int'(REG_QUERY_LAYERS));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		layer_query = value;
		@(negedge clk);
	endtask

	task automatic queue_random(input int n_items);
		int target;
		int n_loads;
		int n_tests;
		bit noisy;
		logic signed [VAL_W-1:0] r;
		target = items_queued + n_items;
		while (items_queued < target) begin
			noisy = ($urandom_range(4) == 0);
			n_loads = ($urandom_range(3) != 0) ? PLANE_COUNT : $urandom_range(1, 4);
			for (int k = 0; k < n_loads; k++) begin
				if (noisy)
					push_load($urandom_range(PLANE_COUNT - 1), $urandom(), $urandom(),
						$urandom(), $urandom());
				else
					push_load(n_loads == PLANE_COUNT ? k : $urandom_range(PLANE_COUNT - 1),
						around_zero(UNIT), around_zero(UNIT), around_zero(UNIT),
						VAL_W'($urandom_range(72 << FRAC_W)) - (VAL_W'(8) <<< FRAC_W));
			end
			n_tests = $urandom_range(3, 20);
			for (int k = 0; k < n_tests; k++) begin
				if (noisy) begin
					push_test($urandom(), $urandom(), $urandom(), $urandom(), pick_layers(),
						ID_W'($urandom()), 1'($urandom()));
				end else begin
					r = ($urandom_range(9) == 0) ? -VAL_W'($urandom_range(8 << FRAC_W))
						: VAL_W'($urandom_range(8 << FRAC_W));
					push_test(around_zero(32 << FRAC_W), around_zero(32 << FRAC_W),
						around_zero(32 << FRAC_W), r, pick_layers(), ID_W'($urandom()),
						k == n_tests - 1);
				end
			end
		end
	endtask

	task automatic run_phase(input logic [LAYER_W-1:0] query, input int n_items,
			input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_query(query);
		queue_random(n_items);
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 26;
		recv_stall_pct = 83;
		push_test('0, '0, '0, '0, ALL_LAYERS, '0, 1'b0);
		push_test('0, '0, '0, -32'sd1, ALL_LAYERS, 24'd1, 1'b0);
		push_test(VMAX, VMAX, VMAX, VMAX, '0, '1, 1'b1);
		push_test(VMIN, VMIN, VMIN, '0, 64'd1, 24'd2, 1'b0);
		push_load(0, UNIT, '0, '0, '0);
		push_test(-UNIT, '0, '0, UNIT, ALL_LAYERS, 24'd3, 1'b0);
		push_test(-UNIT - 1, '0, '0, UNIT, ALL_LAYERS, 24'd4, 1'b1);
		push_load(1, VMIN, VMIN, VMIN, VMIN);
		push_test(VMIN, VMIN, VMIN, VMAX, ALL_LAYERS, 24'd5, 1'b0);
		push_test(VMAX, VMAX, VMAX, VMAX, 64'h8000_0000_0000_0000, 24'd6, 1'b1);
		for (int k = 2; k < PLANE_COUNT; k++)
			push_load(k, k[0] ? VMIN : VMAX, VMAX, k[1] ? VMIN : VMAX, k[0] ? VMAX : VMIN);
		push_test(VMIN, VMAX, VMIN, VMAX, ALL_LAYERS, 24'h5A5A5A, 1'b0);
		push_test(VMAX, VMIN, VMAX, VMIN, ALL_LAYERS, 24'hA5A5A5, 1'b0);
		push_test(VMIN, VMIN, VMIN, VMIN, ALL_LAYERS, 24'h800000, 1'b0);
		push_test('0, '0, '0, VMAX, ALL_LAYERS, 24'h7FFFFF, 1'b1);
		wait_drained();

		run_phase('0, 40, 26, 83);
		run_phase({$urandom(), $urandom()}, 200, 26, 83);
		run_phase(64'h8000_0000_0000_0000, 120, 83, 26);
		run_phase(ALL_LAYERS, 200, 83, 26);
		run_phase({$urandom(), $urandom()}, 140, 0, 0);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
hdl/sfc_pkg.sv
hdl/sphere_frustum_cull.sv
sim/tb_sphere_frustum_cull.sv
